FILE: src/sbs_pkg.sv
// Shared types, constants and register indexes of the beacon scheduler.
// Used by every module of the block; depends on nothing.
package sbs_pkg;

  localparam int SPEED_W   = 10;
  localparam int HEADING_W = 9;
  localparam int PERIOD_W  = 16;
  localparam int SEC_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam int DIV_NUM_W = PERIOD_W + SPEED_W;
  localparam int DIV_DEN_W = SPEED_W;
  localparam int DIV_CNT_W = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd120;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;
  localparam logic [SEC_W-1:0]    SEC_MAX      = 32'hFFFF_FFFF;
  localparam logic signed [10:0]  HALF_TURN    = 11'sd180;
  localparam logic signed [10:0]  FULL_TURN    = 11'sd360;

  localparam logic [DIV_CNT_W-1:0] STEPS_PERIOD = 5'd26;
  localparam logic [DIV_CNT_W-1:0] STEPS_GAIN   = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_FAST_SPEED = 3'd1,
    REG_FAST_PER   = 3'd2,
    REG_SLOW_SPEED = 3'd3,
    REG_SLOW_PER   = 3'd4,
    REG_TURN_HOLD  = 3'd5,
    REG_TURN_MIN   = 3'd6,
    REG_TURN_GAIN  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    CLS_TICK = 3'd0,
    CLS_HOLD = 3'd1,
    CLS_SLOW = 3'd2,
    CLS_FAST = 3'd3,
    CLS_MID  = 3'd4
  } cls_t;

  typedef struct packed {
    logic                enable;
    logic [SPEED_W-1:0]  fast_speed;
    logic [PERIOD_W-1:0] fast_period;
    logic [SPEED_W-1:0]  slow_speed;
    logic [PERIOD_W-1:0] slow_period;
    logic [15:0]         turn_hold_seconds;
    logic [7:0]          turn_min_degrees;
    logic [15:0]         turn_gain;
  } cfg_t;

  typedef struct packed {
    cls_t                 cls;
    logic [SPEED_W-1:0]   speed;
    logic [HEADING_W-1:0] heading;
  } qitem_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/smart_beacon_scheduler_unit.sv
// Top level of the adaptive position-beacon scheduler: configuration registers,
// front end queue, back end sequencer and shared divider. Depends on sbs_pkg.
//
// Each input item is a one-second tick or a position fix; each yields exactly
// one result item with the beacon decision and the beacon period now in force.
// Ticks, fixes while disabled, and fixes below the slow speed need no division.
// A fix above the fast speed takes one division on the shared serial divider,
// for the turn slope term, and one between the slow and fast speeds takes two.
// The divider delivers one quotient bit per cycle, 26 bits for the speed-scaled
// period and 16 bits for the turn slope term. A two-entry queue
// lets the input side keep accepting while the back end works, and the output
// register lets the back end finish the next item while a result waits.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only be changed while no item is in flight.
module smart_beacon_scheduler_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [9:0] ground_speed, [18:10] heading, upper bits zero.
  input  logic [sbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] action: 0 = one-second tick, 1 = position fix.
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] beacon, [16:1] period_now, upper bits zero.
  output logic [sbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbs_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import sbs_pkg::*;

  cfg_t                cfg;
  logic                q_valid;
  qitem_t              q_item;
  logic                q_pop;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                out_beacon;
  logic [PERIOD_W-1:0] out_period;

  // Register file; writes to each register keep only its own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable            <= 1'b1;
      cfg.fast_speed        <= 10'd96;
      cfg.fast_period       <= 16'd40;
      cfg.slow_speed        <= 10'd8;
      cfg.slow_period       <= 16'd1800;
      cfg.turn_hold_seconds <= 16'd15;
      cfg.turn_min_degrees  <= 8'd30;
      cfg.turn_gain         <= 16'd255;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE:     cfg.enable            <= cfg_data[0];
        REG_FAST_SPEED: cfg.fast_speed        <= cfg_data[SPEED_W-1:0];
        REG_FAST_PER:   cfg.fast_period       <= cfg_data[PERIOD_W-1:0];
        REG_SLOW_SPEED: cfg.slow_speed        <= cfg_data[SPEED_W-1:0];
        REG_SLOW_PER:   cfg.slow_period       <= cfg_data[PERIOD_W-1:0];
        REG_TURN_HOLD:  cfg.turn_hold_seconds <= cfg_data;
        REG_TURN_MIN:   cfg.turn_min_degrees  <= cfg_data[7:0];
        REG_TURN_GAIN:  cfg.turn_gain         <= cfg_data;
        default:        cfg.enable            <= cfg.enable;
      endcase
    end
  end

  sbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser[0]),
    .in_speed   (s_axis_tdata[SPEED_W-1:0]),
    .in_heading (s_axis_tdata[SPEED_W+HEADING_W-1:SPEED_W]),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  sbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_beacon (out_beacon),
    .out_period (out_period)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-PERIOD_W-1){1'b0}}, out_period, out_beacon};

endmodule

FILE: src/sbs_front.sv
// Front end: accepts input items, classifies them and queues them.
// Depends on sbs_pkg.
module sbs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  sbs_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [sbs_pkg::SPEED_W-1:0]   in_speed,
  input  logic [sbs_pkg::HEADING_W-1:0] in_heading,
  output logic                          q_valid,
  output sbs_pkg::qitem_t               q_item,
  input  logic                          q_pop
);
  import sbs_pkg::*;

  qitem_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  qitem_t             cls_item;
  logic               push;
  logic               pop;

  // Uses configuration; user must change it only while queue is empty, unchecked.
  always_comb begin
    cls_item.speed   = in_speed;
    cls_item.heading = in_heading;
    if (!in_action) begin
      cls_item.cls = CLS_TICK;
    end else if (!cfg.enable) begin
      cls_item.cls = CLS_HOLD;
    end else if (in_speed < cfg.slow_speed) begin
      cls_item.cls = CLS_SLOW;
    end else if (in_speed > cfg.fast_speed) begin
      cls_item.cls = CLS_FAST;
    end else begin
      cls_item.cls = CLS_MID;
    end
  end

  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/sbs_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on sbs_pkg. A zero divisor yields ones in every computed quotient bit.
module sbs_div (
  input  logic              clk,
  input  logic              rst,
  input  sbs_pkg::div_req_t req,
  output sbs_pkg::div_rsp_t rsp
);
  import sbs_pkg::*;

  logic [DIV_NUM_W-1:0] dvd;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // The dividend is left aligned, so its top bit enters the remainder each step.
  assign trial = {rem, dvd[DIV_NUM_W-1]};
  assign ge    = (trial >= {1'b0, den});
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      den <= req.divisor;
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_NUM_W-2:0], 1'b0};
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: src/sbs_back.sv
// Back end: sequencer that evaluates queued items, keeps the beacon state
// and holds the output register. Depends on sbs_pkg and drives sbs_div.
module sbs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sbs_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  sbs_pkg::qitem_t               q_item,
  output logic                          q_pop,
  output sbs_pkg::div_req_t             div_req,
  input  sbs_pkg::div_rsp_t             div_rsp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_beacon,
  output logic [sbs_pkg::PERIOD_W-1:0]  out_period
);
  import sbs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD1 = 7'b0000010,
    ST_DIV1  = 7'b0000100,
    ST_LOAD2 = 7'b0001000,
    ST_DIV2  = 7'b0010000,
    ST_TURN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t               state;
  qitem_t               cur;
  logic [DIV_NUM_W-1:0] prod;
  logic [PERIOD_W-1:0]  per_calc;
  logic [16:0]          thr;
  logic                 turn;

  logic [HEADING_W-1:0] last_heading;
  logic                 heading_known;
  logic [PERIOD_W-1:0]  period;
  logic [SEC_W-1:0]     seconds_since;

  logic [HEADING_W-1:0] eff_last;
  logic signed [10:0]   hdiff;
  logic signed [10:0]   hfold;
  logic [10:0]          mag;
  logic                 turn_next;
  logic [SEC_W-1:0]     sec_inc;
  logic                 send;
  logic                 is_fix;
  logic                 out_free;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;
  assign is_fix   = cur.cls inside {CLS_SLOW, CLS_FAST, CLS_MID};

  always_comb begin
    div_req.start   = (state == ST_LOAD1) || (state == ST_LOAD2);
    div_req.divisor = cur.speed;
    if (state == ST_LOAD1) begin
      div_req.dividend = prod;
      div_req.steps    = STEPS_PERIOD;
    end else begin
      div_req.dividend = {cfg.turn_gain, {SPEED_W{1'b0}}};
      div_req.steps    = STEPS_GAIN;
    end
  end

  // Turn test: an unseeded heading compares against itself, giving no change.
  always_comb begin
    eff_last = heading_known ? last_heading : cur.heading;
    hdiff    = $signed({2'b00, eff_last}) - $signed({2'b00, cur.heading});
    if (hdiff > HALF_TURN) begin
      hfold = hdiff - FULL_TURN;
    end else if (hdiff < -HALF_TURN) begin
      hfold = hdiff + FULL_TURN;
    end else begin
      hfold = hdiff;
    end
    mag       = hfold[10] ? 11'(-hfold) : 11'(hfold);
    turn_next = ({6'b0, mag} > thr) &&
                (seconds_since > {16'b0, cfg.turn_hold_seconds});
  end

  always_comb begin
    if ((cur.cls == CLS_TICK) && (seconds_since != SEC_MAX)) begin
      sec_inc = seconds_since + 1'b1;
    end else begin
      sec_inc = seconds_since;
    end
    send = turn || (sec_inc > {16'b0, per_calc});
  end

  // The result register fills when an item finishes and empties when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      last_heading  <= '0;
      heading_known <= 1'b0;
      period        <= PERIOD_RESET;
      seconds_since <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.cls)
              CLS_SLOW: state <= ST_DONE;
              CLS_FAST: state <= ST_LOAD2;
              CLS_MID:  state <= ST_LOAD1;
              default:  state <= ST_DONE;
            endcase
          end
        end
        ST_LOAD1: state <= ST_DIV1;
        ST_DIV1: begin
          if (div_rsp.done) begin
            state <= ST_LOAD2;
          end
        end
        ST_LOAD2: state <= ST_DIV2;
        ST_DIV2: begin
          if (div_rsp.done) begin
            state <= ST_TURN;
          end
        end
        ST_TURN: state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state     <= ST_IDLE;
            period    <= per_calc;
            if (is_fix && (!heading_known || turn)) begin
              last_heading  <= cur.heading;
              heading_known <= 1'b1;
            end
            seconds_since <= send ? '0 : sec_inc;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur  <= q_item;
        turn <= 1'b0;
        prod <= {{SPEED_W{1'b0}}, cfg.fast_period} *
                {{PERIOD_W{1'b0}}, cfg.fast_speed};
        case (q_item.cls)
          CLS_SLOW: per_calc <= cfg.slow_period;
          CLS_FAST: per_calc <= cfg.fast_period;
          default:  per_calc <= period;
        endcase
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          per_calc <= (|div_rsp.quotient[DIV_NUM_W-1:PERIOD_W]) ?
                      PERIOD_MAX : div_rsp.quotient[PERIOD_W-1:0];
        end
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          thr <= {9'b0, cfg.turn_min_degrees} + {1'b0, div_rsp.quotient[15:0]};
        end
      end
      ST_TURN: turn <= turn_next;
      ST_DONE: begin
        if (out_free) begin
          out_beacon <= send;
          out_period <= per_calc;
        end
      end
      default: turn <= turn;
    endcase
  end

endmodule

FILE: src/sbs_checker.sv
// Port-level checker for the beacon scheduler, bound to the top level.
// Depends on sbs_pkg.
module sbs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sbs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import sbs_pkg::*;

  logic [2:0] pend;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = s_axis_tvalid && s_axis_tready;
  assign acc_out = m_axis_tvalid && m_axis_tready;

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (acc_in && !acc_out) begin
      pend <= pend + 1'b1;
    end else if (acc_out && !acc_in) begin
      pend <= pend - 1'b1;
    end
  end

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pend != 3'd0))
    else $error("result offered with no item in flight");

  a_bounded_inflight: assert property (@(posedge clk) disable iff (rst)
    pend <= 3'(QUEUE_DEPTH + 2))
    else $error("more items in flight than the block can hold");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (s_axis_tready && !m_axis_tvalid))
    else $error("block not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind smart_beacon_scheduler_unit sbs_checker u_sbs_checker (.*);

FILE: verif/tb_smart_beacon_scheduler_unit.sv
// Self-checking testbench for the adaptive beacon scheduler: a directed table and
// random phases, checked item by item against a cycle-free behavioral predictor.
// Depends on sbs_pkg and smart_beacon_scheduler_unit.
module tb_smart_beacon_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sbs_pkg::*;

  // Run shape. The settle pause and the tail wait share one length. The cycle
  // limit covers the slowest legal run (longest gaps, longest stalls, mid-speed
  // fixes only) several times over.
  localparam int SETTLE_CYCLES   = 60;
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int MAX_REPORTS     = 10;
  localparam int HALF_CIRCLE     = 180;
  localparam int FULL_CIRCLE     = 360;

  // Indexes into the table of fixed register settings below.
  localparam int CFG_RESET     = 0;
  localparam int CFG_OFF       = 1;
  localparam int CFG_ZERO_SLOW = 2;
  localparam int CFG_INVERTED  = 3;
  localparam int CFG_NO_HOLD   = 4;
  localparam int CFG_ALL_MIN   = 5;
  localparam int CFG_ALL_MAX   = 6;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_FIX  = 1'b1
  } action_t;

  typedef struct packed {
    logic                beacon;
    logic [PERIOD_W-1:0] period;
  } beacon_out_t;

  typedef struct {
    int          cfg_sel;
    action_t     act;
    logic [9:0]  spd;
    logic [8:0]  hdg;
    bit          typed;
    beacon_out_t res;
  } step_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DAT_W-1:0]  cfg_data;

  smart_beacon_scheduler_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Register settings, fields in cfg_t order: enable, fast_speed, fast_period,
  // slow_speed, slow_period, turn_hold_seconds, turn_min_degrees, turn_gain.
  cfg_t dir_cfg [7] = '{
    '{1'b1, 10'd96,   16'd40,    10'd8,    16'd1800,  16'd15,    8'd30,  16'd255},
    '{1'b0, 10'd96,   16'd40,    10'd8,    16'd1800,  16'd15,    8'd30,  16'd255},
    '{1'b1, 10'd1023, 16'd65535, 10'd0,    16'd1,     16'd0,     8'd0,   16'd0},
    '{1'b1, 10'd1,    16'd1,     10'd1023, 16'd65535, 16'd65535, 8'd180, 16'd65535},
    '{1'b1, 10'd96,   16'd40,    10'd8,    16'd1800,  16'd0,     8'd30,  16'd255},
    '{1'b1, 10'd1,    16'd1,     10'd1,    16'd1,     16'd0,     8'd0,   16'd0},
    '{1'b1, 10'd1023, 16'd65535, 10'd1023, 16'd65535, 16'd65535, 8'd180, 16'd65535}
  };

  // Directed items. The typed results follow straight from the reset values:
  // the first tick, the slow fix that seeds the course, a fast fix whose course
  // change wraps across north, a turn held back by the hold time, the same turn
  // firing once the hold is zero, a mid-range fix that scales the period, and a
  // zero speed that saturates the period. The remaining rows (more mid-range
  // scaling, exactly the slow and fast speeds, headings past 359, disabled fixes,
  // a fast speed below the slow speed) go through the predictor.
  step_row_t dir_rows [21] = '{
    '{CFG_RESET,     ACT_TICK, 10'd0,    9'd0,   1'b1, '{1'b0, 16'd120}},
    '{CFG_RESET,     ACT_FIX,  10'd0,    9'd0,   1'b1, '{1'b0, 16'd1800}},
    '{CFG_RESET,     ACT_FIX,  10'd1023, 9'd359, 1'b1, '{1'b0, 16'd40}},
    '{CFG_RESET,     ACT_FIX,  10'd1023, 9'd90,  1'b1, '{1'b0, 16'd40}},
    '{CFG_NO_HOLD,   ACT_FIX,  10'd1023, 9'd90,  1'b1, '{1'b1, 16'd40}},
    '{CFG_NO_HOLD,   ACT_FIX,  10'd50,   9'd90,  1'b1, '{1'b0, 16'd76}},
    '{CFG_NO_HOLD,   ACT_FIX,  10'd96,   9'd511, 1'b0, '0},
    '{CFG_NO_HOLD,   ACT_TICK, 10'd0,    9'd0,   1'b0, '0},
    '{CFG_NO_HOLD,   ACT_FIX,  10'd8,    9'd300, 1'b0, '0},
    '{CFG_NO_HOLD,   ACT_FIX,  10'd7,    9'd0,   1'b0, '0},
    '{CFG_OFF,       ACT_FIX,  10'd500,  9'd200, 1'b0, '0},
    '{CFG_OFF,       ACT_TICK, 10'd1023, 9'd511, 1'b0, '0},
    '{CFG_OFF,       ACT_FIX,  10'd1023, 9'd511, 1'b0, '0},
    '{CFG_ZERO_SLOW, ACT_FIX,  10'd0,    9'd0,   1'b1, '{1'b0, 16'd65535}},
    '{CFG_ZERO_SLOW, ACT_FIX,  10'd1023, 9'd180, 1'b0, '0},
    '{CFG_ZERO_SLOW, ACT_TICK, 10'd0,    9'd0,   1'b0, '0},
    '{CFG_ZERO_SLOW, ACT_FIX,  10'd1,    9'd0,   1'b0, '0},
    '{CFG_INVERTED,  ACT_FIX,  10'd1022, 9'd100, 1'b0, '0},
    '{CFG_INVERTED,  ACT_FIX,  10'd1023, 9'd400, 1'b0, '0},
    '{CFG_INVERTED,  ACT_TICK, 10'd0,    9'd0,   1'b0, '0},
    '{CFG_INVERTED,  ACT_TICK, 10'd0,    9'd0,   1'b0, '0}
  };

  // Predictor state: its own copy of the registers and of the scheduler state.
  cfg_t                 sched_cfg;
  logic [HEADING_W-1:0] prev_course;
  logic                 course_known;
  logic [PERIOD_W-1:0]  beacon_period;
  logic [SEC_W-1:0]     secs_since;

  beacon_out_t due_q [$];
  int          items_sent;
  int          results_seen;
  int          beacons_seen;
  int          mismatches;
  int          phases;
  int          cycles;
  int          tx_calm;
  int          rx_calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Cycles to wait before the next item or result. Now and then a calm stretch
  // starts in which nothing idles, so that back-to-back traffic is exercised too.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Behavioral scheduler: applies one item to the predictor state and returns
  // the result item it must produce.
  function automatic beacon_out_t schedule_step(logic is_fix, logic [SPEED_W-1:0] spd,
                                                logic [HEADING_W-1:0] hdg);
    beacon_out_t res;
    logic        fire;
    logic [31:0] scaled;
    logic [31:0] thresh;
    int          diff;
    int          mag;
    fire = 1'b0;
    if (!is_fix) begin
      if (secs_since != SEC_MAX) secs_since = secs_since + 1;
    end else if (sched_cfg.enable) begin
      // The first fix only seeds the course; the change then evaluates as zero.
      if (!course_known) begin
        prev_course  = hdg;
        course_known = 1'b1;
      end
      if (spd < sched_cfg.slow_speed) begin
        beacon_period = sched_cfg.slow_period;
      end else begin
        if (spd > sched_cfg.fast_speed) begin
          beacon_period = sched_cfg.fast_period;
        end else if (spd == 0) begin
          beacon_period = PERIOD_MAX;
        end else begin
          scaled = (32'(sched_cfg.fast_period) * 32'(sched_cfg.fast_speed)) / 32'(spd);
          beacon_period = (scaled > 32'(PERIOD_MAX)) ? PERIOD_MAX : scaled[PERIOD_W-1:0];
        end
        // A zero speed makes the slope term saturate, so no turn can fire.
        thresh = 32'(sched_cfg.turn_min_degrees) +
                 ((spd == 0) ? 32'(PERIOD_MAX) : 32'(sched_cfg.turn_gain) / 32'(spd));
        // Single fold of the course change; headings past 359 are taken as given.
        diff = int'(prev_course) - int'(hdg);
        if (diff > HALF_CIRCLE) diff -= FULL_CIRCLE;
        else if (diff < -HALF_CIRCLE) diff += FULL_CIRCLE;
        mag = (diff < 0) ? -diff : diff;
        if (32'(mag) > thresh && secs_since > 32'(sched_cfg.turn_hold_seconds)) begin
          prev_course = hdg;
          fire        = 1'b1;
        end
      end
    end
    if (fire || secs_since > 32'(beacon_period)) begin
      fire       = 1'b1;
      secs_since = '0;
    end
    res.beacon = fire;
    res.period = beacon_period;
    return res;
  endfunction

  // Offers one input item, waits for it to be taken and files its expected result.
  // valid stays high into the next item when that item has no gap.
  task automatic send_item(input action_t act, input logic [SPEED_W-1:0] spd,
                           input logic [HEADING_W-1:0] hdg, input bit typed,
                           input beacon_out_t typed_res);
    int          gap;
    beacon_out_t due;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(IN_DATA_W - HEADING_W - SPEED_W){1'b0}}, hdg, spd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    due = schedule_step(act == ACT_FIX, spd, hdg);
    due_q.push_back(typed ? typed_res : due);
    items_sent++;
  endtask

  // Rewrites all eight registers once the block has drained. Bits above each
  // register's width carry random junk, which the block must mask off.
  task automatic apply_config(input cfg_t c);
    int          i;
    int          wid;
    logic [15:0] val;
    logic [15:0] word;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (i = 0; i < 8; i++) begin
      case (reg_idx_t'(i))
        REG_ENABLE:     begin val = 16'(c.enable);            wid = 1;  end
        REG_FAST_SPEED: begin val = 16'(c.fast_speed);        wid = 10; end
        REG_FAST_PER:   begin val = c.fast_period;            wid = 16; end
        REG_SLOW_SPEED: begin val = 16'(c.slow_speed);        wid = 10; end
        REG_SLOW_PER:   begin val = c.slow_period;            wid = 16; end
        REG_TURN_HOLD:  begin val = c.turn_hold_seconds;      wid = 16; end
        REG_TURN_MIN:   begin val = 16'(c.turn_min_degrees);  wid = 8;  end
        default:        begin val = c.turn_gain;              wid = 16; end
      endcase
      word = (16'($urandom) & ~((16'd1 << wid) - 16'd1)) | val;
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= word;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sched_cfg = c;
    phases++;
  endtask

  // Result side: stalls at random, then checks each accepted result item
  // against the oldest expectation.
  initial begin : result_check
    int          stall;
    beacon_out_t due;
    logic        got_beacon;
    logic [15:0] got_period;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(rx_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got_beacon = m_axis_tdata[0];
      got_period = m_axis_tdata[PERIOD_W:1];
      results_seen++;
      if (got_beacon === 1'b1) beacons_seen++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with nothing expected: beacon %0b period %0d",
                   results_seen, got_beacon, got_period);
      end else begin
        due = due_q.pop_front();
        if (got_beacon !== due.beacon || got_period !== due.period) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected beacon %0b period %0d, got beacon %0b period %0d",
                     results_seen, due.beacon, due.period, got_beacon, got_period);
        end
      end
    end
  end

  // Input side: reset, directed table, random phases, then drain and verdict.
  initial begin : stimulus
    int                   i;
    int                   k;
    int                   r;
    int                   phase;
    int                   cur_sel;
    int                   course;
    cfg_t                 c;
    action_t              act;
    logic [SPEED_W-1:0]   spd;
    logic [HEADING_W-1:0] hdg;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_ENABLE;
    cfg_data      <= '0;
    sched_cfg     = dir_cfg[CFG_RESET];
    prev_course   = '0;
    course_known  = 1'b0;
    beacon_period = PERIOD_RESET;
    secs_since    = '0;
    course        = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: the registers start at their reset values, and a row that
    // names another setting first drains the block and reloads the registers.
    cur_sel = CFG_RESET;
    for (i = 0; i < $size(dir_rows); i++) begin
      if (dir_rows[i].cfg_sel != cur_sel) begin
        cur_sel = dir_rows[i].cfg_sel;
        apply_config(dir_cfg[cur_sel]);
      end
      send_item(dir_rows[i].act, dir_rows[i].spd, dir_rows[i].hdg, dir_rows[i].typed,
                dir_rows[i].res);
    end

    // Random part. The first two phases enable the block and pin the rest low, then
    // high; later ones mostly use plausible road settings, sometimes disabled,
    // sometimes each field at a random extreme (a zero slow speed included).
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) begin
        c = dir_cfg[CFG_ALL_MIN];
      end else if (phase == 1) begin
        c = dir_cfg[CFG_ALL_MAX];
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          c.enable            = 1'b1;
          c.fast_speed        = $urandom_range(0, 1) ? 10'd1 : 10'd1023;
          c.fast_period       = $urandom_range(0, 1) ? 16'd1 : 16'd65535;
          c.slow_speed        = $urandom_range(0, 2) == 0 ? 10'd0 :
                                ($urandom_range(0, 1) ? 10'd1 : 10'd1023);
          c.slow_period       = $urandom_range(0, 1) ? 16'd1 : 16'd65535;
          c.turn_hold_seconds = $urandom_range(0, 1) ? 16'd0 : 16'd65535;
          c.turn_min_degrees  = $urandom_range(0, 1) ? 8'd0 : 8'd180;
          c.turn_gain         = $urandom_range(0, 1) ? 16'd0 : 16'd65535;
        end else begin
          c.enable            = (r != 1);
          c.fast_speed        = 10'($urandom_range(40, 200));
          c.fast_period       = 16'($urandom_range(5, 120));
          c.slow_speed        = 10'($urandom_range(1, 30));
          c.slow_period       = 16'($urandom_range(20, 400));
          c.turn_hold_seconds = 16'($urandom_range(0, 25));
          c.turn_min_degrees  = 8'($urandom_range(0, 90));
          c.turn_gain         = 16'($urandom_range(0, 600));
        end
      end
      apply_config(c);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // Noise: any action, any speed, headings up to 511.
          act = action_t'($urandom_range(0, 1));
          spd = 10'($urandom);
          hdg = 9'($urandom);
        end else if (r < 55) begin
          // Ticks carry junk in the unused fields.
          act = ACT_TICK;
          spd = 10'($urandom);
          hdg = 9'($urandom);
        end else begin
          // A vehicle on the road: the course drifts, with an occasional sharp
          // turn, and the speed lands around and on the configured boundaries.
          act = ACT_FIX;
          if ($urandom_range(0, 3) == 0) course = $urandom_range(0, 359);
          else course = (course + FULL_CIRCLE + $urandom_range(0, 40) - 20) % FULL_CIRCLE;
          hdg = 9'(course);
          case ($urandom_range(0, 3))
            0:       spd = 10'($urandom_range(0, 20));
            1:       spd = 10'($urandom_range(20, 130));
            2:       spd = 10'($urandom_range(0, 1023));
            default: spd = ($urandom_range(0, 1) ? sched_cfg.fast_speed : sched_cfg.slow_speed)
                           + 10'($urandom_range(0, 2)) - 10'd1;
          endcase
        end
        send_item(act, spd, hdg, 1'b0, '0);
      end
    end

    // Drain: every expectation must be met, then a quiet tail catches strays.
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d items sent (%0d directed) over %0d register settings, %0d cycles",
             items_sent, $size(dir_rows), phases + 1, cycles);
    $display("%0d results checked, %0d beacons, %0d mismatches, %0d left waiting",
             results_seen, beacons_seen, mismatches, due_q.size());
    if (mismatches == 0 && due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sbs_pkg.sv
src/sbs_front.sv
src/sbs_div.sv
src/sbs_back.sv
src/smart_beacon_scheduler_unit.sv
src/sbs_checker.sv
verif/tb_smart_beacon_scheduler_unit.sv
